[design/sorted_multiset_table_unit_defines.svh]
// assertion macros for the sorted multiset table unit
`ifndef SORTED_MULTISET_TABLE_UNIT_DEFINES_SVH
`define SORTED_MULTISET_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SMT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SMT_ASSERT_IMPL(lbl, ante, cons)
`define SMT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/smt_pkg.sv]
// shared types and constants for the sorted multiset table unit
`timescale 1ns / 1ps

package smt_pkg;

  localparam int DEPTH_DEFAULT = 32;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               has_data;
    logic signed [31:0] entry_value;
    logic [5:0]         entry_count;
    logic               is_empty;
    logic               last;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_REM,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] key;
  } cell_ctrl_t;

endpackage

[design/smt_cell.sv]
// one storage cell of the sorted table row
`timescale 1ns / 1ps

module smt_cell (
  input  logic                      clk,
  input  smt_pkg::cell_ctrl_t       ctrl,
  input  logic signed [31:0]        left_val,
  input  logic                      left_lt,
  input  logic signed [31:0]        right_val,
  input  logic signed [31:0]        head_val,
  input  logic                      occupied,
  input  logic                      is_tail,
  input  logic                      shift_sel,
  output logic signed [31:0]        val,
  output logic                      lt,
  output logic                      match
);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      smt_pkg::CELL_CMP: begin
        lt    <= occupied && (val < ctrl.key);
        match <= occupied && (val == ctrl.key);
      end
      smt_pkg::CELL_INS: begin
        if (!lt) begin
          val <= left_lt ? ctrl.key : left_val;
        end
      end
      smt_pkg::CELL_REM: begin
        if (shift_sel) begin
          val <= right_val;
        end
      end
      smt_pkg::CELL_ROT: begin
        val <= is_tail ? head_val : right_val;
      end
      default: begin
      end
    endcase
  end

endmodule

[design/sorted_multiset_table_unit.sv]
// top level of the sorted multiset table unit
// Keeps up to DEPTH signed values in ascending order in a row of cells. An insert,
// remove or unused command has the accept cycle, in which every cell compares its
// entry with the value, and an execute state, in which the row shifts by one place
// if an insert or remove goes through. A read-out rotates the row once, giving one
// result per cycle from the head cell; an empty read-out gives one result. busy is
// high until the last result of a command. Results come on done for one cycle
// each and cannot be held off, so the receiver must take one every cycle.
`timescale 1ns / 1ps

module sorted_multiset_table_unit #(
  parameter int DEPTH = smt_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  smt_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output smt_pkg::res_t result
);

`include "sorted_multiset_table_unit_defines.svh"

  localparam int CW = $clog2(DEPTH + 1);

  smt_pkg::state_t     state, state_next;
  smt_pkg::cmd_t       cmd_r;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       rd_left, rd_left_next;
  logic                done_next;
  smt_pkg::res_t       res_next;
  smt_pkg::cell_ctrl_t ctrl;

  logic signed [31:0]  cell_val [DEPTH];
  logic [DEPTH-1:0]    lt_vec, match_vec, occ, tail, sel;

  assign sel = match_vec | (~match_vec + {{(DEPTH-1){1'b0}}, 1'b1});

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] lv, rv;
    logic               llt;

    assign occ[i]  = CW'(i) < count;
    assign tail[i] = CW'(i) == (count - CW'(1));

    if (i == 0) begin : g_first
      assign lv  = '0;
      assign llt = 1'b1;
    end else begin : g_inner
      assign lv  = cell_val[i-1];
      assign llt = lt_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_lastc
      assign rv = '0;
    end else begin : g_mid
      assign rv = cell_val[i+1];
    end

    smt_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_val  (lv),
      .left_lt   (llt),
      .right_val (rv),
      .head_val  (cell_val[0]),
      .occupied  (occ[i]),
      .is_tail   (tail[i]),
      .shift_sel (sel[i]),
      .val       (cell_val[i]),
      .lt        (lt_vec[i]),
      .match     (match_vec[i])
    );
  end

  assign busy = state != smt_pkg::ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= smt_pkg::ST_IDLE;
      count   <= '0;
      rd_left <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rd_left <= rd_left_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= cmd;
    end
    result <= res_next;
  end

  always_comb begin
    state_next           = state;
    count_next           = count;
    rd_left_next         = rd_left;
    done_next            = 1'b0;
    ctrl.op              = smt_pkg::CELL_HOLD;
    ctrl.key             = cmd_r.value;
    res_next             = '0;
    res_next.status      = smt_pkg::STATUS_OK;
    res_next.entry_count = 6'(count);
    res_next.is_empty    = count == '0;
    res_next.last        = 1'b1;
    case (state)
      smt_pkg::ST_IDLE: begin
        ctrl.op  = smt_pkg::CELL_CMP;
        ctrl.key = cmd.value;
        if (start) begin
          state_next = smt_pkg::ST_EXEC;
        end
      end
      smt_pkg::ST_EXEC: begin
        state_next = smt_pkg::ST_IDLE;
        done_next  = 1'b1;
        case (cmd_r.kind)
          smt_pkg::KIND_INSERT: begin
            if (count == CW'(DEPTH)) begin
              res_next.status = smt_pkg::STATUS_FULL;
            end else begin
              ctrl.op    = smt_pkg::CELL_INS;
              count_next = count + CW'(1);
            end
          end
          smt_pkg::KIND_REMOVE: begin
            if (count == '0) begin
              res_next.status = smt_pkg::STATUS_EMPTY;
            end else if (match_vec == '0) begin
              res_next.status = smt_pkg::STATUS_NOT_FOUND;
            end else begin
              ctrl.op    = smt_pkg::CELL_REM;
              count_next = count - CW'(1);
            end
          end
          smt_pkg::KIND_READ: begin
            if (count != '0) begin
              done_next    = 1'b0;
              rd_left_next = count;
              state_next   = smt_pkg::ST_READ;
            end
          end
          default: begin
          end
        endcase
        res_next.entry_count = 6'(count_next);
        res_next.is_empty    = count_next == '0;
      end
      smt_pkg::ST_READ: begin
        done_next            = 1'b1;
        ctrl.op              = smt_pkg::CELL_ROT;
        res_next.has_data    = 1'b1;
        res_next.entry_value = cell_val[0];
        res_next.last        = rd_left == CW'(1);
        rd_left_next         = rd_left - CW'(1);
        if (rd_left == CW'(1)) begin
          state_next = smt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = smt_pkg::ST_IDLE;
      end
    endcase
  end

  // read-out results come back to back until the last one
  `SMT_ASSERT_NEXT(a_readout_contig, done && !result.last, done)
  `SMT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SMT_ASSERT_IMPL(a_count_bound, 1'b1, count <= CW'(DEPTH))
  `SMT_ASSERT_IMPL(a_end_with_last, $fell(busy) && !$past(rst), done && result.last)
  `SMT_ASSERT_IMPL(a_data_ok, done && result.has_data, result.status == smt_pkg::STATUS_OK)

endmodule

[tb/smt_checker.sv]
// checker for the sorted multiset table unit: predicts results and compares them
`timescale 1ns / 1ps

module smt_checker #(
  parameter int DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  logic          done,
  input  smt_pkg::cmd_t cmd,
  input  smt_pkg::res_t result,
  output int            mismatches,
  output int            outstanding
);
  import smt_pkg::*;

  logic signed [31:0] held_values[$];
  res_t               expected_results[$];
  res_t               want;
  int                 error_count = 0;

  function automatic res_t make_result(input logic [1:0] status, input logic has_data,
                                       input logic signed [31:0] val, input logic last);
    res_t r;
    r.status      = status;
    r.has_data    = has_data;
    r.entry_value = val;
    r.entry_count = 6'(held_values.size());
    r.is_empty    = (held_values.size() == 0);
    r.last        = last;
    return r;
  endfunction

  function automatic void apply_command(input cmd_t c);
    int pos;
    pos = 0;
    case (c.kind)
      KIND_INSERT: begin
        if (held_values.size() >= DEPTH) begin
          expected_results.push_back(make_result(STATUS_FULL, 1'b0, '0, 1'b1));
        end else begin
          // new value goes ahead of any equal entries
          while (pos < held_values.size() && held_values[pos] < c.value) pos++;
          held_values.insert(pos, c.value);
          expected_results.push_back(make_result(STATUS_OK, 1'b0, '0, 1'b1));
        end
      end
      KIND_REMOVE: begin
        if (held_values.size() == 0) begin
          expected_results.push_back(make_result(STATUS_EMPTY, 1'b0, '0, 1'b1));
        end else begin
          while (pos < held_values.size() && held_values[pos] != c.value) pos++;
          if (pos >= held_values.size()) begin
            expected_results.push_back(make_result(STATUS_NOT_FOUND, 1'b0, '0, 1'b1));
          end else begin
            held_values.delete(pos);
            expected_results.push_back(make_result(STATUS_OK, 1'b0, '0, 1'b1));
          end
        end
      end
      KIND_READ: begin
        if (held_values.size() == 0) begin
          expected_results.push_back(make_result(STATUS_OK, 1'b0, '0, 1'b1));
        end else begin
          for (int i = 0; i < held_values.size(); i++)
            expected_results.push_back(make_result(STATUS_OK, 1'b1, held_values[i],
                                                   i == held_values.size() - 1));
        end
      end
      default: begin
        // unused kind leaves the table alone
        expected_results.push_back(make_result(STATUS_OK, 1'b0, '0, 1'b1));
      end
    endcase
  endfunction

  function automatic void report(input string what, input res_t exp_r, input res_t got_r);
    error_count++;
    if (error_count <= 10) begin
      $write("%0t %s: exp st=%0d hd=%0d val=%0d cnt=%0d emp=%0d last=%0d",
             $realtime, what, exp_r.status, exp_r.has_data, exp_r.entry_value,
             exp_r.entry_count, exp_r.is_empty, exp_r.last);
      $display(" | got st=%0d hd=%0d val=%0d cnt=%0d emp=%0d last=%0d",
               got_r.status, got_r.has_data, got_r.entry_value, got_r.entry_count,
               got_r.is_empty, got_r.last);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_values.delete();
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report("result with nothing pending", '0, result);
        end else begin
          want = expected_results.pop_front();
          if (want.status !== result.status || want.has_data !== result.has_data ||
              want.entry_value !== result.entry_value ||
              want.entry_count !== result.entry_count ||
              want.is_empty !== result.is_empty || want.last !== result.last)
            report("result differs", want, result);
        end
      end
      if (start && !busy) apply_command(cmd);
    end
    mismatches  <= error_count;
    outstanding <= expected_results.size();
  end

endmodule

[tb/tb.sv]
// testbench top for the sorted multiset table unit: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb;
  import smt_pkg::*;

  localparam int         DEPTH        = 32;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         RANDOM_ITEMS = 450;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         TAIL_CYCLES  = 40;

  typedef enum int {
    MIX_FILL,
    MIX_BALANCED,
    MIX_DRAIN
  } mix_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  cmd_t cmd;
  res_t result;
  int   mismatches;
  int   outstanding;
  int   idle_cycles = 0;
  bit   gaps_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  sorted_multiset_table_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  smt_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .cmd        (cmd),
    .result     (result),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] k, input logic [31:0] v);
    cmd_t c;
    c.kind  = k;
    c.value = v;
    while (gaps_on && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 32'($urandom_range(0, 16)) - 32'd8;
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [1:0] pick_kind(input mix_t mix);
    int r;
    int ins;
    int rem;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin ins = 75; rem = 10; end
      MIX_DRAIN: begin ins = 15; rem = 70; end
      default:   begin ins = 40; rem = 40; end
    endcase
    if (r < ins) return KIND_INSERT;
    if (r < ins + rem) return KIND_REMOVE;
    if (r < 97) return KIND_READ;
    return KIND_UNUSED;
  endfunction

  initial begin
    int   sent;
    int   phase;
    int   phase_len;
    mix_t mix;
    rst   <= 1'b1;
    start <= 1'b0;
    cmd   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty table cases, then extremes, duplicates, head and tail removal
    send_item(KIND_READ, 32'h1234_5678);
    send_item(KIND_REMOVE, 32'h0000_0000);
    send_item(KIND_UNUSED, 32'hdead_beef);
    send_item(KIND_INSERT, 32'h7fff_ffff);
    send_item(KIND_INSERT, 32'h8000_0000);
    send_item(KIND_INSERT, 32'h0000_0000);
    send_item(KIND_INSERT, 32'hffff_ffff);
    send_item(KIND_INSERT, 32'd5);
    send_item(KIND_INSERT, 32'd5);
    send_item(KIND_INSERT, 32'd3);
    send_item(KIND_READ, 32'h0);
    send_item(KIND_REMOVE, 32'd5);
    send_item(KIND_REMOVE, 32'd7);
    send_item(KIND_REMOVE, 32'h8000_0000);
    send_item(KIND_REMOVE, 32'h7fff_ffff);
    send_item(KIND_UNUSED, 32'h0);
    send_item(KIND_READ, 32'hffff_ffff);
    send_item(KIND_REMOVE, 32'd5);
    send_item(KIND_REMOVE, 32'd3);
    send_item(KIND_REMOVE, 32'h0000_0000);
    send_item(KIND_REMOVE, 32'hffff_ffff);
    send_item(KIND_READ, 32'h0);

    // fill, mixed and drain phases in turn so the table reaches full and empty
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      mix       = mix_t'(phase % 3);
      phase_len = (mix == MIX_FILL) ? $urandom_range(50, 80) : $urandom_range(30, 70);
      repeat (phase_len) begin
        gaps_on = !(sent >= 150 && sent < 250);
        send_item(pick_kind(mix), pick_value());
        sent++;
      end
      phase++;
    end
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
